// ----- hdl/smie_pkg.sv -----
package smie_pkg;

    // sizes
    localparam int DATA_DEPTH_DEF = 1024;
    localparam int REG_COUNT_DEF  = 4;
    localparam int PROG_DEPTH     = 1024;
    localparam int PROG_AW        = $clog2(PROG_DEPTH);
    localparam int ADDR_W         = 10;
    localparam int WORD_W         = 32;
    localparam int IN_TDATA_W     = 128;
    localparam int OUT_TDATA_W    = 48;

    // instruction set
    typedef enum logic [3:0] {
        OP_ADD     = 4'd0,
        OP_MUL     = 4'd1,
        OP_SUB     = 4'd2,
        OP_DIV     = 4'd3,
        OP_COPY    = 4'd4,
        OP_LOAD    = 4'd5,
        OP_JMP     = 4'd6,
        OP_JMF     = 4'd7,
        OP_LESS    = 4'd8,
        OP_GREATER = 4'd9,
        OP_EQUAL   = 4'd10,
        OP_PRINT   = 4'd11,
        OP_PUSH    = 4'd12,
        OP_POP     = 4'd13,
        OP_CALL    = 4'd14,
        OP_RET     = 4'd15
    } opcode_t;

    // operand addressing modes
    typedef enum logic [1:0] {
        MODE_IMM = 2'd0,
        MODE_ABS = 2'd1,
        MODE_REL = 2'd2,
        MODE_REG = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        FAULT_NONE     = 2'd0,
        FAULT_IMM_DEST = 2'd1,
        FAULT_DIV_ZERO = 2'd2,
        FAULT_RANGE    = 2'd3
    } fault_t;

    // one operand, mode in the lowest bits
    typedef struct packed {
        logic [WORD_W-1:0] num;
        logic [1:0]        reg_idx;
        mode_t             mode;
    } operand_t;

    // input item, opcode in the lowest bits
    typedef struct packed {
        operand_t          c;
        operand_t          b;
        operand_t          a;
        logic [ADDR_W-1:0] addr;
        opcode_t           opcode;
    } instr_t;

    // result item, next address in the lowest bits
    typedef struct packed {
        fault_t            fault;
        logic [WORD_W-1:0] print_value;
        logic              print_valid;
        logic [ADDR_W-1:0] next_addr;
    } result_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DST_A,
        ST_SRC_A,
        ST_SRC_B,
        ST_SRC_C,
        ST_EXEC,
        ST_DIV,
        ST_WB,
        ST_PUSH,
        ST_POP_RD,
        ST_POP_WB,
        ST_SP_INC,
        ST_RET0,
        ST_RET1,
        ST_RET2,
        ST_FIN
    } state_t;

    // datapath commands
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_CAPTURE,
        CMD_DST_A,
        CMD_SRC_A,
        CMD_SRC_B,
        CMD_SRC_C,
        CMD_EXEC,
        CMD_WB,
        CMD_PUSH,
        CMD_POP_RD,
        CMD_POP_WB,
        CMD_SP_INC,
        CMD_RET0,
        CMD_RET1,
        CMD_RET2,
        CMD_FIN
    } dp_cmd_t;

    typedef enum logic [1:0] {
        TGT_A,
        TGT_B,
        TGT_C
    } tgt_t;

    typedef struct packed {
        opcode_t opcode;
        fault_t  fault;
        logic    clr_last;
        logic    div_done;
        logic    out_free;
    } dp_status_t;

    // arithmetic, compare and move operations
    function automatic logic is_alu(input opcode_t op);
        return (op == OP_ADD) || (op == OP_MUL) || (op == OP_SUB) || (op == OP_DIV) ||
               (op == OP_COPY) || (op == OP_LOAD) || (op == OP_LESS) ||
               (op == OP_GREATER) || (op == OP_EQUAL);
    endfunction

endpackage

// ----- hdl/stack_machine_instruction_execute_unit.sv -----
// states after accept, all ending in FIN: jmp none; print/jmf SRC_A; call PUSH; push
// SRC_A, PUSH; ret RET0-2; pop DST_A, POP_RD, POP_WB, SP_INC; copy/load DST_A, SRC_B,
// EXEC, WB; other alu ops also SRC_C; divide also DIV, a 32-step bit-serial divider.
// One item at a time: next item taken the cycle after its result is registered; one
// data store access per controller step sets the step count. Reset: registers 0 and
// 1 load DATA_DEPTH, others zero; store cleared one word per cycle with s_tready low
module stack_machine_instruction_execute_unit #(
    parameter int DATA_DEPTH = smie_pkg::DATA_DEPTH_DEF,
    parameter int REG_COUNT  = smie_pkg::REG_COUNT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // opcode, instr_addr, a_mode, a_reg, a_num, b_mode, b_reg, b_num,
    // c_mode, c_reg, c_num
    input  logic [smie_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // next_addr, print_valid, print_value, fault
    output logic [smie_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    smie_pkg::instr_t     instr_in;
    smie_pkg::result_t    result;
    smie_pkg::dp_status_t status;
    smie_pkg::dp_cmd_t    cmd;

    assign instr_in = smie_pkg::instr_t'(s_tdata[$bits(smie_pkg::instr_t)-1:0]);

    smie_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .in_opcode (instr_in.opcode),
        .s_ready   (s_tready),
        .status    (status),
        .cmd       (cmd)
    );

    smie_dp #(
        .DATA_DEPTH (DATA_DEPTH),
        .REG_COUNT  (REG_COUNT)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .instr_in (instr_in),
        .status   (status),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (result)
    );

    // zero padding up to whole bytes
    assign m_tdata = {{(smie_pkg::OUT_TDATA_W - $bits(smie_pkg::result_t)){1'b0}}, result};

`ifndef ASSERT_OFF
    // clearing pass keeps the input closed right after reset
    a_clear_closed: assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("input open right after reset");

    // a faulting instruction never prints
    a_no_print_on_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[10] |-> m_tdata[44:43] == smie_pkg::FAULT_NONE)
        else $error("print with fault");

    // print value is zero unless something was printed
    a_print_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[10] |-> m_tdata[42:11] == 32'd0)
        else $error("stray print value");
`endif

endmodule

// ----- hdl/smie_ram.sv -----
module smie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/smie_div.sv -----
module smie_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [32:0] rem_sh;
    logic [32:0] rem_diff;
    logic        ge;

    // one restoring step per cycle on magnitudes
    always_comb begin
        rem_sh   = {rem_reg, quo_reg[31]};
        rem_diff = rem_sh - {1'b0, dvs_reg};
        ge       = rem_sh >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend[31] ? (~dividend + 32'd1) : dividend;
            dvs_next  = divisor[31] ? (~divisor + 32'd1) : divisor;
            neg_next  = dividend[31] ^ divisor[31];
        end else if (busy_reg) begin
            rem_next = ge ? rem_diff[31:0] : rem_sh[31:0];
            quo_next = {quo_reg[30:0], ge};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    // truncating quotient, sign restored
    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 32'd1) : quo_reg;

endmodule

// ----- hdl/smie_dp.sv -----
module smie_dp #(
    parameter int DATA_DEPTH = smie_pkg::DATA_DEPTH_DEF,
    parameter int REG_COUNT  = smie_pkg::REG_COUNT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  smie_pkg::dp_cmd_t    cmd,
    input  smie_pkg::instr_t     instr_in,
    output smie_pkg::dp_status_t status,
    output logic                 m_valid,
    input  logic                 m_ready,
    output smie_pkg::result_t    m_result
);

    localparam int DAW = $clog2(DATA_DEPTH);
    localparam int RIW = $clog2(REG_COUNT);
    localparam int PROG_AW_L = smie_pkg::PROG_AW;

    // instruction and operand values
    smie_pkg::instr_t  instr_reg, instr_next;
    logic [31:0]       va_reg, va_next;
    logic [31:0]       vb_reg, vb_next;
    logic [31:0]       vc_reg, vc_next;
    logic [31:0]       res_reg, res_next;
    smie_pkg::fault_t  fault_reg, fault_next;
    logic              pend_reg, pend_next;
    smie_pkg::tgt_t    pend_tgt_reg, pend_tgt_next;
    logic              dst_rf_reg, dst_rf_next;
    logic [1:0]        dst_ridx_reg, dst_ridx_next;
    logic [DAW-1:0]    dst_addr_reg, dst_addr_next;
    logic [DAW-1:0]    clr_reg, clr_next;
    logic [31:0]       regs_reg [REG_COUNT];
    logic [31:0]       regs_next [REG_COUNT];
    logic              out_valid_reg, out_valid_next;
    smie_pkg::result_t out_data_reg, out_data_next;

    // operand evaluation
    smie_pkg::operand_t cur_op;
    smie_pkg::tgt_t     src_tgt;
    logic [4:0]         cur_ridx;
    logic [31:0]        regval;
    logic [33:0]        idx;
    logic               idx_ok;
    logic               is_mem;
    smie_pkg::fault_t   src_fault;
    smie_pkg::fault_t   dst_fault;
    smie_pkg::fault_t   cur_fault;
    logic [31:0]        src_val;
    logic [31:0]        va_eff, vb_eff, vc_eff;
    logic [31:0]        sp, fp, sp_m1, fp_p1;
    logic [31:0]        push_val;
    logic [4:0]         dst_ridx_ext;
    logic               wb_en;
    logic [31:0]        wb_val;
    logic [PROG_AW_L-1:0] fall;
    logic [31:0]        target;
    logic               take;

    // memory and divider ports
    logic              ram_we;
    logic [DAW-1:0]    ram_waddr;
    logic [31:0]       ram_wdata;
    logic [DAW-1:0]    ram_raddr;
    logic [31:0]       ram_rdata;
    logic              div_start;
    logic              div_done;
    logic [31:0]       div_quo;

    function automatic logic in_range(input logic [31:0] v);
        return !v[31] && (v < 32'(DATA_DEPTH));
    endfunction

    function automatic logic [31:0] alu(input smie_pkg::opcode_t op,
                                        input logic [31:0] x, input logic [31:0] y);
        logic [31:0] r;
        case (op)
            smie_pkg::OP_ADD:     r = x + y;
            smie_pkg::OP_MUL:     r = x * y;
            smie_pkg::OP_SUB:     r = x - y;
            smie_pkg::OP_LESS:    r = {31'd0, $signed(x) < $signed(y)};
            smie_pkg::OP_GREATER: r = {31'd0, $signed(x) > $signed(y)};
            smie_pkg::OP_EQUAL:   r = {31'd0, x == y};
            default:              r = x;
        endcase
        return r;
    endfunction

    smie_ram #(
        .WIDTH (32),
        .DEPTH (DATA_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    smie_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (vb_eff),
        .divisor  (vc_eff),
        .done     (div_done),
        .quotient (div_quo)
    );

    // operand selection, one register read per cycle
    always_comb begin
        case (cmd)
            smie_pkg::CMD_SRC_B: begin
                cur_op  = instr_reg.b;
                src_tgt = smie_pkg::TGT_B;
            end
            smie_pkg::CMD_SRC_C: begin
                cur_op  = instr_reg.c;
                src_tgt = smie_pkg::TGT_C;
            end
            default: begin
                cur_op  = instr_reg.a;
                src_tgt = smie_pkg::TGT_A;
            end
        endcase
        cur_ridx = {3'd0, cur_op.reg_idx};
        regval   = (cur_ridx < 5'(REG_COUNT)) ? regs_reg[cur_ridx[RIW-1:0]] : 32'd0;
        if (cur_op.mode == smie_pkg::MODE_ABS) begin
            idx = {{2{cur_op.num[31]}}, cur_op.num};
        end else begin
            idx = {{2{regval[31]}}, regval} + {{2{cur_op.num[31]}}, cur_op.num};
        end
        idx_ok    = !idx[33] && (idx < 34'(DATA_DEPTH));
        is_mem    = (cur_op.mode == smie_pkg::MODE_ABS) || (cur_op.mode == smie_pkg::MODE_REL);
        src_fault = (is_mem && !idx_ok) ? smie_pkg::FAULT_RANGE : smie_pkg::FAULT_NONE;
        dst_fault = (cur_op.mode == smie_pkg::MODE_IMM) ? smie_pkg::FAULT_IMM_DEST : src_fault;
        src_val   = (cur_op.mode == smie_pkg::MODE_IMM) ? cur_op.num : regval;
    end

    // values with a store read landing this cycle
    always_comb begin
        va_eff = (pend_reg && (pend_tgt_reg == smie_pkg::TGT_A)) ? ram_rdata : va_reg;
        vb_eff = (pend_reg && (pend_tgt_reg == smie_pkg::TGT_B)) ? ram_rdata : vb_reg;
        vc_eff = (pend_reg && (pend_tgt_reg == smie_pkg::TGT_C)) ? ram_rdata : vc_reg;
        sp     = regs_reg[1];
        fp     = regs_reg[0];
        sp_m1  = sp - 32'd1;
        fp_p1  = fp + 32'd1;
        push_val = (instr_reg.opcode == smie_pkg::OP_CALL) ?
                   (32'(instr_reg.addr) + 32'd1) : va_eff;
        dst_ridx_ext = {3'd0, dst_ridx_reg};
    end

    // next-address selection for the result item
    always_comb begin
        fall   = PROG_AW_L'(instr_reg.addr) + PROG_AW_L'(1);
        target = 32'd0;
        take   = 1'b0;
        case (instr_reg.opcode)
            smie_pkg::OP_JMP, smie_pkg::OP_CALL: begin
                take   = instr_reg.a.mode == smie_pkg::MODE_ABS;
                target = instr_reg.a.num;
            end
            smie_pkg::OP_JMF: begin
                take   = (va_eff == 32'd0) && (instr_reg.b.mode == smie_pkg::MODE_ABS);
                target = instr_reg.b.num;
            end
            smie_pkg::OP_RET: begin
                take   = 1'b1;
                target = vc_eff;
            end
            default: begin
                take   = 1'b0;
                target = 32'd0;
            end
        endcase
        if (fault_reg != smie_pkg::FAULT_NONE) begin
            take = 1'b0;
        end
    end

    // command decode
    always_comb begin
        instr_next     = instr_reg;
        va_next        = va_reg;
        vb_next        = vb_reg;
        vc_next        = vc_reg;
        res_next       = res_reg;
        fault_next     = fault_reg;
        pend_next      = 1'b0;
        pend_tgt_next  = pend_tgt_reg;
        dst_rf_next    = dst_rf_reg;
        dst_ridx_next  = dst_ridx_reg;
        dst_addr_next  = dst_addr_reg;
        clr_next       = clr_reg;
        regs_next      = regs_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        cur_fault      = smie_pkg::FAULT_NONE;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr      = '0;
        div_start      = 1'b0;
        wb_en          = 1'b0;
        wb_val         = '0;

        // capture a store read issued last cycle
        if (pend_reg) begin
            case (pend_tgt_reg)
                smie_pkg::TGT_A: va_next = ram_rdata;
                smie_pkg::TGT_B: vb_next = ram_rdata;
                smie_pkg::TGT_C: vc_next = ram_rdata;
                default: ;
            endcase
        end
        if (div_done) begin
            res_next = div_quo;
        end

        case (cmd)
            smie_pkg::CMD_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + DAW'(1);
            end
            smie_pkg::CMD_CAPTURE: begin
                instr_next = instr_in;
                fault_next = smie_pkg::FAULT_NONE;
            end
            smie_pkg::CMD_DST_A: begin
                cur_fault     = dst_fault;
                dst_rf_next   = cur_op.mode == smie_pkg::MODE_REG;
                dst_ridx_next = cur_op.reg_idx;
                dst_addr_next = idx[DAW-1:0];
            end
            smie_pkg::CMD_SRC_A, smie_pkg::CMD_SRC_B, smie_pkg::CMD_SRC_C: begin
                cur_fault = src_fault;
                if (src_fault == smie_pkg::FAULT_NONE) begin
                    if (is_mem) begin
                        ram_raddr     = idx[DAW-1:0];
                        pend_next     = 1'b1;
                        pend_tgt_next = src_tgt;
                    end else begin
                        case (src_tgt)
                            smie_pkg::TGT_A: va_next = src_val;
                            smie_pkg::TGT_B: vb_next = src_val;
                            smie_pkg::TGT_C: vc_next = src_val;
                            default: ;
                        endcase
                    end
                end
            end
            smie_pkg::CMD_EXEC: begin
                if (instr_reg.opcode == smie_pkg::OP_DIV) begin
                    if (vc_eff == 32'd0) begin
                        cur_fault = smie_pkg::FAULT_DIV_ZERO;
                    end else begin
                        div_start = 1'b1;
                    end
                end else begin
                    res_next = alu(instr_reg.opcode, vb_eff, vc_eff);
                end
            end
            smie_pkg::CMD_WB: begin
                wb_en  = 1'b1;
                wb_val = res_reg;
            end
            smie_pkg::CMD_PUSH: begin
                if (!in_range(sp_m1)) begin
                    cur_fault = smie_pkg::FAULT_RANGE;
                end else begin
                    ram_we       = 1'b1;
                    ram_waddr    = sp_m1[DAW-1:0];
                    ram_wdata    = push_val;
                    regs_next[1] = sp_m1;
                end
            end
            smie_pkg::CMD_POP_RD: begin
                if (!in_range(sp)) begin
                    cur_fault = smie_pkg::FAULT_RANGE;
                end else begin
                    ram_raddr     = sp[DAW-1:0];
                    pend_next     = 1'b1;
                    pend_tgt_next = smie_pkg::TGT_B;
                end
            end
            smie_pkg::CMD_POP_WB: begin
                wb_en  = 1'b1;
                wb_val = vb_eff;
            end
            smie_pkg::CMD_SP_INC: begin
                regs_next[1] = sp + 32'd1;
            end
            smie_pkg::CMD_RET0: begin
                va_next = fp;
                if (!in_range(fp) || !in_range(fp_p1)) begin
                    cur_fault = smie_pkg::FAULT_RANGE;
                end else begin
                    ram_raddr     = fp[DAW-1:0];
                    pend_next     = 1'b1;
                    pend_tgt_next = smie_pkg::TGT_B;
                end
            end
            smie_pkg::CMD_RET1: begin
                // frame pointer is still unchanged here
                ram_raddr     = fp_p1[DAW-1:0];
                pend_next     = 1'b1;
                pend_tgt_next = smie_pkg::TGT_C;
            end
            smie_pkg::CMD_RET2: begin
                regs_next[1] = va_reg + 32'd2;
                regs_next[0] = vb_eff;
            end
            smie_pkg::CMD_FIN: begin
                out_valid_next            = 1'b1;
                out_data_next.next_addr   = take ? smie_pkg::ADDR_W'(target[PROG_AW_L-1:0])
                                                 : smie_pkg::ADDR_W'(fall);
                out_data_next.fault       = fault_reg;
                out_data_next.print_valid = (instr_reg.opcode == smie_pkg::OP_PRINT) &&
                                            (fault_reg == smie_pkg::FAULT_NONE);
                out_data_next.print_value = out_data_next.print_valid ? va_eff : 32'd0;
            end
            default: ;
        endcase

        if (cur_fault != smie_pkg::FAULT_NONE) begin
            fault_next = cur_fault;
        end

        // destination write, register file or store
        if (wb_en) begin
            if (dst_rf_reg) begin
                if (dst_ridx_ext < 5'(REG_COUNT)) begin
                    regs_next[dst_ridx_ext[RIW-1:0]] = wb_val;
                end
            end else begin
                ram_we    = 1'b1;
                ram_waddr = dst_addr_reg;
                ram_wdata = wb_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= 1'b0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++) begin
                regs_reg[i] <= (i < 2) ? 32'(DATA_DEPTH) : 32'd0;
            end
        end else begin
            pend_reg      <= pend_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            regs_reg      <= regs_next;
        end
        instr_reg    <= instr_next;
        va_reg       <= va_next;
        vb_reg       <= vb_next;
        vc_reg       <= vc_next;
        res_reg      <= res_next;
        fault_reg    <= fault_next;
        pend_tgt_reg <= pend_tgt_next;
        dst_rf_reg   <= dst_rf_next;
        dst_ridx_reg <= dst_ridx_next;
        dst_addr_reg <= dst_addr_next;
        out_data_reg <= out_data_next;
    end

    // status back to the controller
    assign status.opcode   = instr_reg.opcode;
    assign status.fault    = cur_fault;
    assign status.clr_last = clr_reg == DAW'(DATA_DEPTH - 1);
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || m_ready;

    assign m_valid  = out_valid_reg;
    assign m_result = out_data_reg;

endmodule

// ----- hdl/smie_ctrl.sv -----
module smie_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  smie_pkg::opcode_t    in_opcode,
    output logic                 s_ready,
    input  smie_pkg::dp_status_t status,
    output smie_pkg::dp_cmd_t    cmd
);

    smie_pkg::state_t state_reg, state_next;
    logic             faulted;

    assign faulted = status.fault != smie_pkg::FAULT_NONE;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            smie_pkg::ST_CLEAR: begin
                if (status.clr_last) state_next = smie_pkg::ST_IDLE;
            end
            smie_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (smie_pkg::is_alu(in_opcode) || (in_opcode == smie_pkg::OP_POP)) begin
                        state_next = smie_pkg::ST_DST_A;
                    end else if (in_opcode == smie_pkg::OP_JMP) begin
                        state_next = smie_pkg::ST_FIN;
                    end else if (in_opcode == smie_pkg::OP_CALL) begin
                        state_next = smie_pkg::ST_PUSH;
                    end else if (in_opcode == smie_pkg::OP_RET) begin
                        state_next = smie_pkg::ST_RET0;
                    end else begin
                        state_next = smie_pkg::ST_SRC_A;
                    end
                end
            end
            smie_pkg::ST_DST_A: begin
                if (faulted) begin
                    state_next = smie_pkg::ST_FIN;
                end else if (status.opcode == smie_pkg::OP_POP) begin
                    state_next = smie_pkg::ST_POP_RD;
                end else begin
                    state_next = smie_pkg::ST_SRC_B;
                end
            end
            smie_pkg::ST_SRC_A: begin
                if (!faulted && (status.opcode == smie_pkg::OP_PUSH)) begin
                    state_next = smie_pkg::ST_PUSH;
                end else begin
                    state_next = smie_pkg::ST_FIN;
                end
            end
            smie_pkg::ST_SRC_B: begin
                if (faulted) begin
                    state_next = smie_pkg::ST_FIN;
                end else if ((status.opcode == smie_pkg::OP_COPY) ||
                             (status.opcode == smie_pkg::OP_LOAD)) begin
                    state_next = smie_pkg::ST_EXEC;
                end else begin
                    state_next = smie_pkg::ST_SRC_C;
                end
            end
            smie_pkg::ST_SRC_C: begin
                state_next = faulted ? smie_pkg::ST_FIN : smie_pkg::ST_EXEC;
            end
            smie_pkg::ST_EXEC: begin
                if (faulted) begin
                    state_next = smie_pkg::ST_FIN;
                end else if (status.opcode == smie_pkg::OP_DIV) begin
                    state_next = smie_pkg::ST_DIV;
                end else begin
                    state_next = smie_pkg::ST_WB;
                end
            end
            smie_pkg::ST_DIV: begin
                if (status.div_done) state_next = smie_pkg::ST_WB;
            end
            smie_pkg::ST_WB:     state_next = smie_pkg::ST_FIN;
            smie_pkg::ST_PUSH:   state_next = smie_pkg::ST_FIN;
            smie_pkg::ST_POP_RD: begin
                state_next = faulted ? smie_pkg::ST_FIN : smie_pkg::ST_POP_WB;
            end
            smie_pkg::ST_POP_WB: state_next = smie_pkg::ST_SP_INC;
            smie_pkg::ST_SP_INC: state_next = smie_pkg::ST_FIN;
            smie_pkg::ST_RET0: begin
                state_next = faulted ? smie_pkg::ST_FIN : smie_pkg::ST_RET1;
            end
            smie_pkg::ST_RET1:   state_next = smie_pkg::ST_RET2;
            smie_pkg::ST_RET2:   state_next = smie_pkg::ST_FIN;
            smie_pkg::ST_FIN: begin
                if (status.out_free) state_next = smie_pkg::ST_IDLE;
            end
            default: state_next = smie_pkg::ST_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb begin
        s_ready = 1'b0;
        cmd     = smie_pkg::CMD_NONE;
        case (state_reg)
            smie_pkg::ST_CLEAR:  cmd = smie_pkg::CMD_CLEAR;
            smie_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) cmd = smie_pkg::CMD_CAPTURE;
            end
            smie_pkg::ST_DST_A:  cmd = smie_pkg::CMD_DST_A;
            smie_pkg::ST_SRC_A:  cmd = smie_pkg::CMD_SRC_A;
            smie_pkg::ST_SRC_B:  cmd = smie_pkg::CMD_SRC_B;
            smie_pkg::ST_SRC_C:  cmd = smie_pkg::CMD_SRC_C;
            smie_pkg::ST_EXEC:   cmd = smie_pkg::CMD_EXEC;
            smie_pkg::ST_WB:     cmd = smie_pkg::CMD_WB;
            smie_pkg::ST_PUSH:   cmd = smie_pkg::CMD_PUSH;
            smie_pkg::ST_POP_RD: cmd = smie_pkg::CMD_POP_RD;
            smie_pkg::ST_POP_WB: cmd = smie_pkg::CMD_POP_WB;
            smie_pkg::ST_SP_INC: cmd = smie_pkg::CMD_SP_INC;
            smie_pkg::ST_RET0:   cmd = smie_pkg::CMD_RET0;
            smie_pkg::ST_RET1:   cmd = smie_pkg::CMD_RET1;
            smie_pkg::ST_RET2:   cmd = smie_pkg::CMD_RET2;
            smie_pkg::ST_FIN: begin
                if (status.out_free) cmd = smie_pkg::CMD_FIN;
            end
            default: cmd = smie_pkg::CMD_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= smie_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
